@@ hw/rtl/pse_pkg.sv @@
// types and constants shared by the postfix stack evaluator modules
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

  localparam int unsigned DATA_W = 32;

  // ascii codes of the characters the evaluator understands
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DONE     = 3'd1,
    ST_FEW      = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_BADCHAR  = 3'd4,
    ST_BADEND   = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FETCH,
    S_DIV,
    S_EMIT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    ld_in;      // capture an accepted request
    logic    push;       // push the captured digit
    logic    rd;         // read the entry below the top
    logic    apply;      // replace the two top entries by the alu result
    logic    div_start;  // launch the divider
    logic    div_apply;  // replace the two top entries by the quotient
    logic    emit;       // load the result register
    logic    clear;      // empty the stack
    status_t status;     // status to report with emit
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic full;
    logic lt2;
    logic one;
    logic rhs_zero;
    logic last;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/postfix_stack_evaluator.sv @@
// Postfix expression evaluator. Each request carries one ASCII character; a digit is pushed
// onto an operand stack of STACK_DEPTH 32-bit entries, and + - * / replace the two top
// entries by their result (two's complement with wrap, division truncating toward zero).
// Every request gives exactly one result: status, value and tlast copied from the request.
// The first error of an expression is latched and later characters are ignored; the request
// marked with tlast reports done-valid with the value, or the error, and empties the stack.
// Sequence with the output register free: a digit, an ignored character or one that fails
// in decode passes capture, decode and emit; + - * and / by zero add the stack memory read
// below the top; any other / also waits for the one-bit-per-cycle divider.
// The next request is taken while a result still waits in the output register.
// uses pse_pkg, pse_ctrl, pse_dp
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] symbol
  input  wire logic        s_tlast,   // end_of_expr
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [2:0] status, [34:3] value, [39:35] zero
  output logic             m_tlast    // expr_done
);
  import pse_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        st;
  status_t           out_status;
  logic [DATA_W-1:0] out_value;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_symbol  (s_tdata),
    .in_last    (s_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'b0, out_value, out_status};

endmodule

`default_nettype wire

@@ hw/rtl/pse_div.sv @@
// iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero
// uses pse_pkg for the data width
`timescale 1ns / 1ps
`default_nettype none

module pse_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [pse_pkg::DATA_W-1:0] dividend,
  input  wire logic [pse_pkg::DATA_W-1:0] divisor,
  output logic                           done,
  output logic [pse_pkg::DATA_W-1:0]      quot
);
  import pse_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] q;
  logic [DATA_W-1:0] d;
  logic              neg;
  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   sh;
  logic [DATA_W:0]   diff;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign sh   = {rem, q[DATA_W-1]};
  assign diff = sh - {1'b0, d};
  assign ge   = !diff[DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      d   <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
      q   <= {q[DATA_W-2:0], ge};
    end
  end

  assign quot = neg ? (DATA_W'(0) - q) : q;

endmodule

`default_nettype wire

@@ hw/rtl/pse_ctrl.sv @@
// controller state machine of the postfix evaluator: sequencing and the latched error
// uses pse_pkg for the state, status and command types
`timescale 1ns / 1ps
`default_nettype none

module pse_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pse_pkg::dp_status_t st,
  output pse_pkg::ctrl_cmd_t       cmd
);
  import pse_pkg::*;

  state_t  state;
  state_t  state_next;
  status_t err;
  status_t err_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      err   <= ST_OK;
    end else begin
      state <= state_next;
      err   <= err_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        priority if (err != ST_OK || st.is_digit || st.lt2 || !st.is_op) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        priority if (st.is_div && !st.rhs_zero) begin
          state_next = S_DIV;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DIV: begin
        if (st.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.status = ST_OK;
    err_next = err;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      S_EVAL: begin
        if (err == ST_OK) begin
          priority if (st.is_digit) begin
            if (st.full) err_next = ST_OVERFLOW;
            else cmd.push = 1'b1;
          end else if (st.lt2) begin
            err_next = ST_FEW;
          end else if (!st.is_op) begin
            err_next = ST_BADCHAR;
          end else begin
            cmd.rd = 1'b1;
          end
        end
      end
      S_FETCH: begin
        priority if (st.is_div && st.rhs_zero) begin
          err_next = ST_DIVZERO;
        end else if (st.is_div) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.apply = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_apply = st.div_done;
      end
      S_EMIT: begin
        priority if (!st.last) begin
          cmd.status = err;
        end else if (err != ST_OK) begin
          cmd.status = err;
        end else if (st.one) begin
          cmd.status = ST_DONE;
        end else begin
          cmd.status = ST_BADEND;
        end
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.clear = st.last;
          if (st.last) err_next = ST_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/pse_dp.sv @@
// datapath of the postfix evaluator: operand stack, alu, divider and result register
// uses pse_pkg and instantiates pse_div
`timescale 1ns / 1ps
`default_nettype none

module pse_dp #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [7:0]                 in_symbol,
  input  wire logic                       in_last,
  input  wire pse_pkg::ctrl_cmd_t         cmd,
  output pse_pkg::dp_status_t             st,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output pse_pkg::status_t                out_status,
  output logic [pse_pkg::DATA_W-1:0]      out_value,
  output logic                            out_last
);
  import pse_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // top of stack lives in tos, entries below it in the memory
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] lhs;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [7:0]        sym;
  logic              last;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] quot;
  logic              div_done;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      sym  <= in_symbol;
      last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && count != '0) mem[cnt_m1[AW-1:0]] <= tos;
    if (cmd.rd) lhs <= mem[cnt_m2[AW-1:0]];
  end

  always_comb begin
    unique case (sym)
      CH_PLUS:  alu_res = lhs + tos;
      CH_MINUS: alu_res = lhs - tos;
      default:  alu_res = lhs * tos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.push) tos <= DATA_W'(sym - CH_ZERO);
    else if (cmd.apply) tos <= alu_res;
    else if (cmd.div_apply) tos <= quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.apply || cmd.div_apply) begin
      count <= cnt_m1;
    end
  end

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (lhs),
    .divisor  (tos),
    .done     (div_done),
    .quot     (quot)
  );

  // result register, freed in the same cycle it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_value  <= (cmd.status == ST_DONE) ? tos : '0;
      out_last   <= last;
    end
  end

  always_comb begin
    st          = '0;
    st.is_digit = (sym >= CH_ZERO) && (sym <= CH_NINE);
    st.is_op    = (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_MUL) ||
                  (sym == CH_DIV);
    st.is_div   = (sym == CH_DIV);
    st.full     = (count == CW'(STACK_DEPTH));
    st.lt2      = (count < CW'(2));
    st.one      = (count == CW'(1));
    st.rhs_zero = (tos == '0);
    st.last     = last;
    st.div_done = div_done;
    st.out_free = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !st.full)
    else $error("push onto a full stack");
  a_value_only_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_DONE) |-> (out_value == '0))
    else $error("value present without a valid result");
  a_pop_needs_two: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply || cmd.div_start) |-> (count >= CW'(2)))
    else $error("operator applied with fewer than two operands");
`endif

endmodule

`default_nettype wire
